// File: sv/bcb_pkg.sv
package bcb_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [31:0] BASE_ADDRESS_RESET = 32'h43c0_0000;

   localparam logic [2:0] CMD_WRITE   = 3'd1;
   localparam logic [2:0] CMD_READ    = 3'd2;
   localparam logic [2:0] CMD_WRITE8  = 3'd3;
   localparam logic [2:0] CMD_READ8   = 3'd4;
   localparam logic [2:0] CMD_READ32  = 3'd5;
   localparam logic [2:0] CMD_RMW     = 3'd6;

   localparam logic [7:0] CMD_CODE_MIN = 8'd1;
   localparam logic [7:0] CMD_CODE_MAX = 8'd6;

   localparam logic [1:0] KIND_RESPONSE = 2'd0;
   localparam logic [1:0] KIND_WRITE    = 2'd1;
   localparam logic [1:0] KIND_READ     = 2'd2;

   typedef enum logic [3:0] {
      PH_TAG,
      PH_CMD,
      PH_OFFS,
      PH_MASK,
      PH_VAL,
      PH_SIZE,
      PH_SDATA,
      PH_WAIT
   } phase_type;

   typedef enum logic [2:0] {
      BEAT_WRITE,
      BEAT_TAG,
      BEAT_STATUS,
      BEAT_BYTE,
      BEAT_READ
   } beat_type;

   // One job holds every result beat of one accepted item, in the order
   // write, tag, status, data bytes, read.
   typedef struct packed {
      logic        do_write;
      logic        do_ack;
      logic        status;
      logic [2:0]  byte_count;
      logic        do_read;
      logic [7:0]  tag;
      logic [31:0] addr;
      logic [31:0] word;
   } job_type;

endpackage

// File: sv/bcb_front.sv
module bcb_front
   import bcb_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        mode,
   input  logic [7:0]  host_byte,
   input  logic [31:0] read_data,
   input  logic [31:0] base_address,
   output logic        job_push,
   output job_type     job
);

   localparam int         OFFSET_BYTES = (OFFSET_BITS + 7) / 8;
   localparam logic [1:0] OFFSET_LAST  = 2'(OFFSET_BYTES - 1);

   phase_type              phase_ff, phase_in, phase_step;
   logic [7:0]             tag_ff, tag_in;
   logic [2:0]             cmd_ff, cmd_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in, offset_new, addr_offset;
   logic [15:0]            remaining_ff, remaining_in, remaining_new, remaining_dec;
   logic [1:0]             index_ff, index_in, index_next;
   logic [31:0]            value_ff, value_in, value_new;
   logic [31:0]            mask_ff, mask_in, mask_new;

   logic        host_event, data_event;
   logic [31:0] shifted, bus_addr;
   logic        gather_last, misaligned, code_valid;

   assign host_event    = accept && !mode && (phase_ff != PH_WAIT);
   assign data_event    = accept && mode && (phase_ff == PH_WAIT);
   assign shifted       = 32'(host_byte) << {index_ff, 3'b000};
   assign offset_new    = offset_ff | shifted[OFFSET_BITS-1:0];
   assign remaining_new = remaining_ff | shifted[15:0];
   assign value_new     = value_ff | shifted;
   assign mask_new      = mask_ff | shifted;
   assign remaining_dec = remaining_ff - 16'd1;
   assign misaligned    = offset_ff[1:0] != 2'b00;
   assign code_valid    = (host_byte >= CMD_CODE_MIN) && (host_byte <= CMD_CODE_MAX);
   assign addr_offset   = (phase_ff == PH_OFFS) ? offset_new : offset_ff;
   assign bus_addr      = base_address + 32'(addr_offset);
   assign index_next    = gather_last ? 2'd0 : index_ff + 2'd1;

   always_comb begin
      case (phase_ff)
         PH_OFFS: gather_last = index_ff == OFFSET_LAST;
         PH_SIZE: gather_last = index_ff == 2'd1;
         default: gather_last = index_ff == 2'd3;
      endcase
   end

   // next phase
   always_comb begin
      phase_step = phase_ff;
      case (phase_ff)
         PH_TAG: phase_step = PH_CMD;
         PH_CMD: phase_step = code_valid ? PH_OFFS : PH_TAG;
         PH_OFFS: begin
            if (gather_last) begin
               case (cmd_ff)
                  CMD_WRITE: phase_step = PH_VAL;
                  CMD_READ:  phase_step = PH_WAIT;
                  CMD_RMW:   phase_step = PH_MASK;
                  default:   phase_step = PH_SIZE;
               endcase
            end
         end
         PH_MASK: begin
            if (gather_last) phase_step = PH_VAL;
         end
         PH_VAL: begin
            if (gather_last) phase_step = (cmd_ff == CMD_RMW) ? PH_WAIT : PH_TAG;
         end
         PH_SIZE: begin
            if (gather_last) begin
               if (cmd_ff == CMD_WRITE8) begin
                  phase_step = (remaining_new == 16'd0) ? PH_TAG : PH_SDATA;
               end else begin
                  phase_step = (remaining_new != 16'd0) ? PH_WAIT : PH_TAG;
               end
            end
         end
         PH_SDATA: begin
            if (remaining_dec == 16'd0) phase_step = PH_TAG;
         end
         PH_WAIT: begin
            if ((cmd_ff == CMD_READ8 || cmd_ff == CMD_READ32) && remaining_dec != 16'd0) begin
               phase_step = PH_WAIT;
            end else begin
               phase_step = PH_TAG;
            end
         end
         default: phase_step = PH_TAG;
      endcase
      phase_in = (host_event || data_event) ? phase_step : phase_ff;
   end

   // field gathering and job building
   always_comb begin
      tag_in       = tag_ff;
      cmd_in       = cmd_ff;
      offset_in    = offset_ff;
      remaining_in = remaining_ff;
      index_in     = index_ff;
      value_in     = value_ff;
      mask_in      = mask_ff;
      job          = '0;
      job.tag      = tag_ff;
      job.addr     = bus_addr;
      if (host_event) begin
         case (phase_ff)
            PH_TAG: tag_in = host_byte;
            PH_CMD: begin
               if (code_valid) begin
                  cmd_in    = host_byte[2:0];
                  offset_in = '0;
                  index_in  = 2'd0;
               end
            end
            PH_OFFS: begin
               offset_in = offset_new;
               index_in  = index_next;
               if (gather_last) begin
                  case (cmd_ff)
                     CMD_WRITE: value_in = '0;
                     CMD_READ:  job.do_read = 1'b1;
                     CMD_RMW:   mask_in = '0;
                     default:   remaining_in = '0;
                  endcase
               end
            end
            PH_MASK: begin
               mask_in  = mask_new;
               index_in = index_next;
               if (gather_last) value_in = '0;
            end
            PH_VAL: begin
               value_in = value_new;
               index_in = index_next;
               if (gather_last) begin
                  if (cmd_ff == CMD_RMW) begin
                     job.do_read = 1'b1;
                  end else if (misaligned) begin
                     job.do_ack = 1'b1;
                     job.status = 1'b1;
                  end else begin
                     job.do_write = 1'b1;
                     job.word     = value_new;
                     job.do_ack   = 1'b1;
                  end
               end
            end
            PH_SIZE: begin
               remaining_in = remaining_new;
               index_in     = index_next;
               if (gather_last) begin
                  job.do_ack = (cmd_ff != CMD_WRITE8) || (remaining_new == 16'd0);
                  if (cmd_ff != CMD_WRITE8) job.do_read = remaining_new != 16'd0;
               end
            end
            PH_SDATA: begin
               job.do_write = 1'b1;
               job.word     = 32'(host_byte);
               remaining_in = remaining_dec;
               job.do_ack   = remaining_dec == 16'd0;
            end
            default: ;
         endcase
      end else if (data_event) begin
         case (cmd_ff)
            CMD_READ: begin
               job.do_ack = 1'b1;
               job.status = misaligned;
               if (!misaligned) begin
                  job.byte_count = 3'd4;
                  job.word       = read_data;
               end
            end
            CMD_READ8, CMD_READ32: begin
               job.byte_count = (cmd_ff == CMD_READ8) ? 3'd1 : 3'd4;
               job.word       = read_data;
               remaining_in   = remaining_dec;
               job.do_read    = remaining_dec != 16'd0;
            end
            CMD_RMW: begin
               job.do_write = 1'b1;
               job.word     = (read_data & ~mask_ff) | (value_ff & mask_ff);
               job.do_ack   = 1'b1;
            end
            default: ;
         endcase
      end
      job_push = job.do_write || job.do_ack || (job.byte_count != 3'd0) || job.do_read;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TAG;
         tag_ff       <= '0;
         cmd_ff       <= '0;
         offset_ff    <= '0;
         remaining_ff <= '0;
         index_ff     <= '0;
         value_ff     <= '0;
         mask_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         tag_ff       <= tag_in;
         cmd_ff       <= cmd_in;
         offset_ff    <= offset_in;
         remaining_ff <= remaining_in;
         index_ff     <= index_in;
         value_ff     <= value_in;
         mask_ff      <= mask_in;
      end
   end

endmodule

// File: sv/bcb_queue.sv
module bcb_queue
   import bcb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   job_type               entries_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = count_ff == COUNT_BITS'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: sv/bcb_back.sv
module bcb_back
   import bcb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_empty,
   input  job_type     job,
   output logic        job_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_response_byte,
   output logic [31:0] rsp_bus_address,
   output logic [31:0] rsp_bus_write_data,
   output logic        rsp_last
);

   logic        write_ff, write_in;
   logic        tag_pend_ff, tag_pend_in;
   logic        status_pend_ff, status_pend_in;
   logic [2:0]  bytes_ff, bytes_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;
   logic        read_ff, read_in;
   logic [7:0]  tag_ff;
   logic        status_ff;
   logic [31:0] addr_ff, word_ff;

   logic        busy, beat_pop, load;
   logic [3:0]  pending;
   beat_type    beat;

   assign busy     = write_ff || tag_pend_ff || status_pend_ff || (bytes_ff != 3'd0) || read_ff;
   assign pending  = 4'(write_ff) + 4'(tag_pend_ff) + 4'(status_pend_ff) + 4'(bytes_ff)
                     + 4'(read_ff);
   assign rsp_last = pending == 4'd1;
   assign rsp_empty = !busy;
   assign beat_pop = rsp_pop && busy;
   assign load     = !job_empty && (!busy || (beat_pop && rsp_last));
   assign job_pop  = load;

   always_comb begin
      if (write_ff)              beat = BEAT_WRITE;
      else if (tag_pend_ff)      beat = BEAT_TAG;
      else if (status_pend_ff)   beat = BEAT_STATUS;
      else if (bytes_ff != 3'd0) beat = BEAT_BYTE;
      else                       beat = BEAT_READ;
   end

   // next beat flags
   always_comb begin
      write_in       = write_ff;
      tag_pend_in    = tag_pend_ff;
      status_pend_in = status_pend_ff;
      bytes_in       = bytes_ff;
      byte_idx_in    = byte_idx_ff;
      read_in        = read_ff;
      if (load) begin
         write_in       = job.do_write;
         tag_pend_in    = job.do_ack;
         status_pend_in = job.do_ack;
         bytes_in       = job.byte_count;
         byte_idx_in    = 2'd0;
         read_in        = job.do_read;
      end else if (beat_pop) begin
         case (beat)
            BEAT_WRITE:  write_in = 1'b0;
            BEAT_TAG:    tag_pend_in = 1'b0;
            BEAT_STATUS: status_pend_in = 1'b0;
            BEAT_BYTE: begin
               bytes_in    = bytes_ff - 3'd1;
               byte_idx_in = byte_idx_ff + 2'd1;
            end
            default:     read_in = 1'b0;
         endcase
      end
   end

   // beat outputs
   always_comb begin
      rsp_kind           = KIND_RESPONSE;
      rsp_response_byte  = '0;
      rsp_bus_address    = '0;
      rsp_bus_write_data = '0;
      case (beat)
         BEAT_WRITE: begin
            rsp_kind           = KIND_WRITE;
            rsp_bus_address    = addr_ff;
            rsp_bus_write_data = word_ff;
         end
         BEAT_TAG:    rsp_response_byte = tag_ff;
         BEAT_STATUS: rsp_response_byte = 8'(status_ff);
         BEAT_BYTE:   rsp_response_byte = 8'(word_ff >> {byte_idx_ff, 3'b000});
         default: begin
            rsp_kind        = KIND_READ;
            rsp_bus_address = addr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ff       <= 1'b0;
         tag_pend_ff    <= 1'b0;
         status_pend_ff <= 1'b0;
         bytes_ff       <= '0;
         byte_idx_ff    <= '0;
         read_ff        <= 1'b0;
      end else begin
         write_ff       <= write_in;
         tag_pend_ff    <= tag_pend_in;
         status_pend_ff <= status_pend_in;
         bytes_ff       <= bytes_in;
         byte_idx_ff    <= byte_idx_in;
         read_ff        <= read_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tag_ff    <= job.tag;
         status_ff <= job.status;
         addr_ff   <= job.addr;
         word_ff   <= job.word;
      end
   end

endmodule

// File: sv/host_command_bus_bridge.sv
// Host command bus bridge. Each req_ beat is either a host command byte
// (req_mode 0) or the data word answering an outstanding bus read (req_mode 1).
// The front parser takes one beat per cycle whenever req_full is low and
// turns it into a job; a job queue of QUEUE_DEPTH entries feeds the result
// sequencer, which emits one rsp_ beat per cycle while rsp_pop is high: bus
// writes, bus read requests and host response bytes, 0 to 6 beats per req_ beat,
// with rsp_last on the final one. Sustained rate is one req_ beat per cycle
// while jobs average a single result, otherwise one result beat per cycle as
// set by the sequencer. Bus reads are answered by feeding the read data back
// in as a req_ beat; host bytes arriving while a read is pending are dropped.
// csr_write_data sets the base address added to every command offset.
module host_command_bus_bridge
   import bcb_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_mode,
   input  logic [7:0]  req_host_byte,
   input  logic [31:0] req_read_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_response_byte,
   output logic [31:0] rsp_bus_address,
   output logic [31:0] rsp_bus_write_data,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   logic [31:0] base_address_ff, base_address_in;
   logic        accept;
   logic        job_push, job_pop, job_empty;
   job_type     front_job, queue_job;

   assign accept          = req_push && !req_full;
   assign base_address_in = csr_write_enable ? csr_write_data : base_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= BASE_ADDRESS_RESET;
      end else begin
         base_address_ff <= base_address_in;
      end
   end

   bcb_front #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .mode         (req_mode),
      .host_byte    (req_host_byte),
      .read_data    (req_read_data),
      .base_address (base_address_ff),
      .job_push     (job_push),
      .job          (front_job)
   );

   bcb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (front_job),
      .full      (req_full),
      .pop       (job_pop),
      .pop_data  (queue_job),
      .empty     (job_empty)
   );

   bcb_back u_back (
      .clock              (clock),
      .reset              (reset),
      .job_empty          (job_empty),
      .job                (queue_job),
      .job_pop            (job_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_kind           (rsp_kind),
      .rsp_response_byte  (rsp_response_byte),
      .rsp_bus_address    (rsp_bus_address),
      .rsp_bus_write_data (rsp_bus_write_data),
      .rsp_last           (rsp_last)
   );

endmodule
